### rtl/core/kse_pkg.sv
// Shared types and constants for the keyword substitution encoder.
// Used by the channel interfaces, the alphabet builder and the top level.
// No dependencies.
package kse_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W      = 5;
  localparam int CHAR_W        = 8;
  localparam int KEY_BITS      = ALPHABET_SIZE * LETTER_W;
  localparam int LOW_W         = 60;
  localparam int MID_W         = 60;
  localparam int HIGH_W        = 10;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 60;
  localparam int NUM_STAGES    = 5;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CHAR_W-1:0]   char_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHIFT      = 3'd0,
    REG_KEY_LENGTH = 3'd1,
    REG_KEY_LOW    = 3'd2,
    REG_KEY_MID    = 3'd3,
    REG_KEY_HIGH   = 3'd4
  } kse_cfg_reg_e;

  // Configuration as seen by the alphabet builder.
  typedef struct packed {
    letter_t               key_length;
    logic [KEY_BITS-1:0]   keys;
  } kse_cfg_t;

  // Derived alphabet: distinct key letter count and the two lookup tables.
  typedef struct packed {
    letter_t                        count;
    letter_t [ALPHABET_SIZE-1:0]    key_tab;
    letter_t [ALPHABET_SIZE-1:0]    plain_tab;
  } kse_alpha_t;

endpackage

### rtl/core/kse_if.sv
// Valid/ready channel interfaces of the keyword substitution encoder.
// Depends on kse_pkg for the payload widths.
interface kse_plain_if;
  import kse_pkg::*;
  logic  valid;
  logic  ready;
  char_t plain_char;
  modport source (output valid, output plain_char, input ready);
  modport sink   (input valid, input plain_char, output ready);
endinterface

interface kse_enc_if;
  import kse_pkg::*;
  logic  valid;
  logic  ready;
  char_t encoded_char;
  modport source (output valid, output encoded_char, input ready);
  modport sink   (input valid, input encoded_char, output ready);
endinterface

interface kse_cfg_if;
  import kse_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/kse_alphabet.sv
// Builds the cipher lookup tables from the configuration in three register levels.
// Depends on kse_pkg.
module kse_alphabet (
  input  logic               clk_i,
  input  kse_pkg::kse_cfg_t  cfg_i,
  output kse_pkg::kse_alpha_t alpha_o
);
  import kse_pkg::*;

  letter_t code [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid_key;

  logic [ALPHABET_SIZE-1:0] first_d, first_q;
  logic [ALPHABET_SIZE-1:0] used_d, used_q;

  letter_t [ALPHABET_SIZE-1:0] rank_d, rank_q;
  letter_t [ALPHABET_SIZE-1:0] urank_d, urank_q;
  letter_t                     count_d, count_q;

  letter_t [ALPHABET_SIZE-1:0] key_tab_d, key_tab_q;
  letter_t [ALPHABET_SIZE-1:0] plain_tab_d, plain_tab_q;

  // A key letter counts when it lies inside the key length and names a letter.
  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      code[i]      = cfg_i.keys[LETTER_W*i +: LETTER_W];
      valid_key[i] = (LETTER_W'(i) < cfg_i.key_length) &&
                     (code[i] < LETTER_W'(ALPHABET_SIZE));
    end
  end

  // Level one: first occurrences and the set of letters the key uses.
  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      first_d[i] = valid_key[i];
      for (int j = 0; j < i; j++) begin
        if (valid_key[j] && (code[j] == code[i])) first_d[i] = 1'b0;
      end
      used_d[i] = 1'b0;
      for (int j = 0; j < ALPHABET_SIZE; j++) begin
        if (valid_key[j] && (code[j] == LETTER_W'(i))) used_d[i] = 1'b1;
      end
    end
  end

  // Level two: rank of each distinct key letter and of each letter left out.
  always_comb begin
    logic [ALPHABET_SIZE-1:0] mask;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      mask       = (ALPHABET_SIZE'(1) << i) - ALPHABET_SIZE'(1);
      rank_d[i]  = LETTER_W'($countones(first_q & mask));
      urank_d[i] = LETTER_W'($countones(~used_q & mask));
    end
    count_d = LETTER_W'($countones(first_q));
  end

  // Level three: invert the ranks into position-indexed tables.
  always_comb begin
    for (int p = 0; p < ALPHABET_SIZE; p++) begin
      key_tab_d[p]   = '0;
      plain_tab_d[p] = '0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        if (first_q[i] && (rank_q[i] == LETTER_W'(p))) key_tab_d[p] |= code[i];
        if (!used_q[i] && (urank_q[i] == LETTER_W'(p))) plain_tab_d[p] |= LETTER_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    used_q      <= used_d;
    rank_q      <= rank_d;
    urank_q     <= urank_d;
    count_q     <= count_d;
    key_tab_q   <= key_tab_d;
    plain_tab_q <= plain_tab_d;
  end

  assign alpha_o.count     = count_q;
  assign alpha_o.key_tab   = key_tab_q;
  assign alpha_o.plain_tab = plain_tab_q;

endmodule

### rtl/core/keyword_substitution_encoder.sv
// Top level of the keyword substitution encoder: configuration registers and item pipeline.
// Depends on kse_pkg, the interfaces in kse_if and kse_alphabet.
//
//   channel  role     payload                  accepted when
//   plain_i  sink     plain_char   [7:0]       plain_i.valid && plain_i.ready
//   enc_o    source   encoded_char [7:0]       enc_o.valid && enc_o.ready
//   cfg_i    sink     index [2:0], data [59:0] cfg_i.valid && cfg_i.ready
//
// One item enters per cycle unless a stall on enc_o backs up the pipeline;
// the rate is set by the five-stage item pipeline, which holds one item per stage.
// The cipher tables are rebuilt continuously from the configuration registers by a
// three-level register chain that runs alongside the pipeline, so each stage reads
// the level that has caught up with the configuration by the time the item gets there.
// Reset clears the stage valid bits and the configuration registers.
// A stall on enc_o holds each full stage whose later stages are all full; empty stages
// still take items, so nothing is lost or repeated; cfg_i is always ready.
module keyword_substitution_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  kse_plain_if.sink    plain_i,
  kse_enc_if.source    enc_o,
  kse_cfg_if.sink      cfg_i
);
  import kse_pkg::*;

  // Configuration registers.
  letter_t           shift_q;
  letter_t           key_length_q;
  logic [LOW_W-1:0]  key_low_q;
  logic [MID_W-1:0]  key_mid_q;
  logic [HIGH_W-1:0] key_high_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= '0;
      key_length_q <= '0;
      key_low_q    <= '0;
      key_mid_q    <= '0;
      key_high_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SHIFT:      shift_q      <= cfg_i.data[LETTER_W-1:0];
        REG_KEY_LENGTH: key_length_q <= cfg_i.data[LETTER_W-1:0];
        REG_KEY_LOW:    key_low_q    <= cfg_i.data[LOW_W-1:0];
        REG_KEY_MID:    key_mid_q    <= cfg_i.data[MID_W-1:0];
        REG_KEY_HIGH:   key_high_q   <= cfg_i.data[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // The user changes the tables only with the pipeline empty; the block does not check it.
  kse_cfg_t   cfg;
  kse_alpha_t alpha;

  assign cfg.key_length = key_length_q;
  assign cfg.keys       = {key_high_q, key_mid_q, key_low_q};

  kse_alphabet u_alphabet (
    .clk_i   (clk_i),
    .cfg_i   (cfg),
    .alpha_o (alpha)
  );

  // Stage handshake: a stage moves when it is empty or the next one moves.
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || enc_o.ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  assign plain_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= plain_i.valid;
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (adv[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // Stage one: input register.
  char_t char1_q;

  // Stage two: letter test and alphabet index.
  char_t   char2_q;
  logic    upper2_q, upper2_d;
  letter_t idx2_q, idx2_d;

  // Stage three: position in the cipher alphabet, with the shift taken out.
  char_t   char3_q;
  logic    upper3_q;
  letter_t pos3_q, pos3_d;

  // Stage four: which table the position falls in, and the index into it.
  char_t   char4_q;
  logic    upper4_q;
  logic    hit4_q, hit4_d;
  letter_t sel4_q, sel4_d;

  // Stage five: output register.
  char_t   out5_q, out5_d;

  letter_t         shift_mod;
  logic [LETTER_W:0] diff;
  letter_t         letter;

  always_comb begin
    upper2_d = (char1_q >= CHAR_A) && (char1_q <= CHAR_Z);
    idx2_d   = LETTER_W'(char1_q - CHAR_A);
  end

  // Shift values past the alphabet wrap once; the position wraps on a borrow.
  always_comb begin
    shift_mod = (shift_q >= LETTER_W'(ALPHABET_SIZE)) ?
                shift_q - LETTER_W'(ALPHABET_SIZE) : shift_q;
    diff      = {1'b0, idx2_q} - {1'b0, shift_mod};
    pos3_d    = diff[LETTER_W] ? LETTER_W'(diff + (LETTER_W+1)'(ALPHABET_SIZE))
                               : diff[LETTER_W-1:0];
  end

  // Positions below the distinct key letter count hold key letters; the rest hold
  // the unused letters in alphabetical order.
  always_comb begin
    hit4_d = pos3_q < alpha.count;
    sel4_d = hit4_d ? pos3_q : pos3_q - alpha.count;
  end

  always_comb begin
    letter = hit4_q ? alpha.key_tab[sel4_q] : alpha.plain_tab[sel4_q];
    out5_d = upper4_q ? CHAR_A + {{(CHAR_W-LETTER_W){1'b0}}, letter} : char4_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      char1_q <= plain_i.plain_char;
    end
    if (adv[1]) begin
      char2_q  <= char1_q;
      upper2_q <= upper2_d;
      idx2_q   <= idx2_d;
    end
    if (adv[2]) begin
      char3_q  <= char2_q;
      upper3_q <= upper2_q;
      pos3_q   <= pos3_d;
    end
    if (adv[3]) begin
      char4_q  <= char3_q;
      upper4_q <= upper3_q;
      hit4_q   <= hit4_d;
      sel4_q   <= sel4_d;
    end
    if (adv[4]) begin
      out5_q <= out5_d;
    end
  end

  assign enc_o.valid        = valid_q[NUM_STAGES-1];
  assign enc_o.encoded_char = out5_q;

endmodule
